// File: hdl/dwf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwf_pkg
// Shared types and constants of the dedup worklist FIFO: request and status
// codes, seen-bit memory geometry and the controller/datapath interface.
// ----------------------------------------------------------------------------
package dwf_pkg;

   // request codes
   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_POP    = 2'd1,
      REQ_QUERY  = 2'd2,
      REQ_REWIND = 2'd3
   } req_code_type;

   // result status codes
   typedef enum logic [2:0] {
      STS_PUSHED    = 3'd0,
      STS_DUPLICATE = 3'd1,
      STS_POPPED    = 3'd2,
      STS_POP_EMPTY = 3'd3,
      STS_FULL      = 3'd4,
      STS_DONE      = 3'd5
   } status_code_type;

   localparam int VALUE_W     = 16;
   localparam int CAP_W       = 11;
   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   // seen bitmap: 65536 bits stored as 4096 rows of 16
   localparam int SEEN_COL_W  = 4;
   localparam int SEEN_ROW_W  = VALUE_W - SEEN_COL_W;
   localparam int SEEN_WIDTH  = 1 << SEEN_COL_W;
   localparam int SEEN_ROWS   = 1 << SEEN_ROW_W;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request word, launch RAM reads
      logic fire;      // commit request, load result register
      logic clear_en;  // write one zero row of the seen bitmap
   } dwf_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;  // last seen row being cleared
      logic out_busy;    // result register full and stalled
   } dwf_sts_type;

endpackage
`default_nettype wire

// File: hdl/dedup_worklist_fifo_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dedup_worklist_fifo_unit
// Breadth-first worklist FIFO that stores each value at most once.
// ----------------------------------------------------------------------------
// Each request word pushes a value, pops the oldest unread entry, asks
// whether a value was ever pushed, or rewinds the read pointer to the first
// stored entry; every request returns exactly one result word. Entries are
// never removed, so membership means "ever pushed", tracked as one seen bit
// per 16-bit value in a 4096 x 16 RAM. The accept cycle launches registered
// reads of the seen row and the entry store, the execute state then computes
// the result and writes the row and entry back; the next word is taken only
// after that write-back. The result sits in an output register, so a new
// request is accepted while the previous result waits on rsp_stall; only
// when a second result is ready and the first is still stalled does the
// unit hold. After reset the seen bitmap is cleared one row per cycle, and
// req_stall stays high until that clearing pass is done. Capacity writes
// are taken at any time, but should be made only while the unit is idle. A
// push when the fill count has reached min(capacity, DEPTH) returns a full
// error; a capacity of zero blocks every push.
// ----------------------------------------------------------------------------
module dedup_worklist_fifo_unit
   import dwf_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_type,
   input  wire logic [VALUE_W-1:0] req_value,
   // result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [VALUE_W-1:0]      rsp_popped_value,
   output logic                    rsp_is_member,
   output logic                    rsp_is_empty,
   // capacity register
   input  wire logic               csr_wr_en,
   input  wire logic [CAP_W-1:0]   csr_wr_data
);

   dwf_cmd_type cmd;
   dwf_sts_type sts;

   // sequencing: clear pass, idle, execute
   dwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // storage, pointers and result register
   dwf_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_type         (req_type),
      .req_value        (req_value),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_is_member    (rsp_is_member),
      .rsp_is_empty     (rsp_is_empty)
   );

endmodule
`default_nettype wire

// File: hdl/dwf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwf_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while rd_en is low.
// ----------------------------------------------------------------------------
module dwf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hdl/dwf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwf_ctrl
// Controller: clearing pass after reset, then accept / execute sequencing.
// ----------------------------------------------------------------------------
module dwf_ctrl
   import dwf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire dwf_sts_type sts,
   output dwf_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      load;
   logic      fire;

   always_comb begin
      state_in = state_ff;
      load     = req_valid && !req_stall_ff;
      fire     = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (load) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // wait while the previous word still sits in the result register
            if (!sts.out_busy) begin
               fire     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         req_stall_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
      end
   end

   assign req_stall    = req_stall_ff;
   assign cmd.load     = load;
   assign cmd.fire     = fire;
   assign cmd.clear_en = (state_ff == ST_CLEAR);

   // stall is low exactly in the idle state
   a_stall_idle: assert property (@(posedge clock) disable iff (reset)
      req_stall_ff == (state_ff != ST_IDLE))
      else $error("req_stall out of step with state");

   // an accepted word is always executed next
   a_load_exec: assert property (@(posedge clock) disable iff (reset)
      load |=> state_ff == ST_EXEC)
      else $error("accepted word not executed");

   // no commit while clearing the bitmap
   a_no_fire_clear: assert property (@(posedge clock) disable iff (reset)
      !(fire && cmd.clear_en))
      else $error("commit during clearing pass");

endmodule
`default_nettype wire

// File: hdl/dwf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dwf_datapath
// Datapath: seen bitmap and entry store RAMs, pointers, capacity register
// and the result register.
// ----------------------------------------------------------------------------
module dwf_datapath
   import dwf_pkg::*;
#(
   parameter int DEPTH = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dwf_cmd_type        cmd,
   output dwf_sts_type             sts,
   input  wire logic [1:0]         req_type,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire logic               csr_wr_en,
   input  wire logic [CAP_W-1:0]   csr_wr_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [VALUE_W-1:0]      rsp_popped_value,
   output logic                    rsp_is_member,
   output logic                    rsp_is_empty
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int WIDE = (CW > CAP_W) ? CW : CAP_W;

   // request word
   req_code_type               req_type_ff;
   logic [VALUE_W-1:0]         value_ff;

   // state
   logic [CAP_W-1:0]           cap_ff;
   logic [CW-1:0]              stored_count_ff, stored_count_in;
   logic [CW-1:0]              read_index_ff, read_index_in;
   logic [SEEN_ROW_W-1:0]      clear_addr_ff;

   // result register
   logic                       rsp_valid_ff;
   status_code_type            status_ff, status_in;
   logic [VALUE_W-1:0]         popped_ff, popped_in;
   logic                       member_ff, member_in;
   logic                       empty_ff, empty_in;

   // RAM ports
   logic [SEEN_WIDTH-1:0]      seen_row;
   logic [SEEN_WIDTH-1:0]      seen_wr_data;
   logic [SEEN_ROW_W-1:0]      seen_wr_addr;
   logic                       seen_wr_en;
   logic [VALUE_W-1:0]         entry_rd;
   logic                       push_ok;

   logic                       seen_bit;
   logic [WIDE-1:0]            cap_eff;
   logic                       full;

   dwf_ram #(
      .WIDTH (SEEN_WIDTH),
      .DEPTH (SEEN_ROWS)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_wr_en),
      .wr_addr (seen_wr_addr),
      .wr_data (seen_wr_data),
      .rd_en   (cmd.load),
      .rd_addr (req_value[VALUE_W-1:SEEN_COL_W]),
      .rd_data (seen_row)
   );

   dwf_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (cmd.fire && push_ok),
      .wr_addr (stored_count_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_en   (cmd.load),
      .rd_addr (read_index_ff[AW-1:0]),
      .rd_data (entry_rd)
   );

   assign seen_bit = seen_row[value_ff[SEEN_COL_W-1:0]];
   assign cap_eff  = (WIDE'(cap_ff) > WIDE'(DEPTH)) ? WIDE'(DEPTH) : WIDE'(cap_ff);
   assign full     = WIDE'(stored_count_ff) >= cap_eff;

   always_comb begin
      stored_count_in = stored_count_ff;
      read_index_in   = read_index_ff;
      status_in       = STS_DONE;
      popped_in       = '0;
      member_in       = 1'b0;
      push_ok         = 1'b0;
      case (req_type_ff)
         REQ_PUSH: begin
            member_in = 1'b1;
            if (full) begin
               status_in = STS_FULL;
               member_in = seen_bit;
            end else if (seen_bit) begin
               status_in = STS_DUPLICATE;
            end else begin
               status_in       = STS_PUSHED;
               push_ok         = 1'b1;
               stored_count_in = stored_count_ff + CW'(1);
            end
         end
         REQ_POP: begin
            if (read_index_ff < stored_count_ff) begin
               status_in     = STS_POPPED;
               popped_in     = entry_rd;
               read_index_in = read_index_ff + CW'(1);
            end else begin
               status_in = STS_POP_EMPTY;
            end
         end
         REQ_QUERY: begin
            member_in = seen_bit;
         end
         REQ_REWIND: begin
            read_index_in = '0;
         end
         default: begin
            status_in = STS_DONE;
         end
      endcase
      empty_in = read_index_in >= stored_count_in;
   end

   // seen write port: zero rows during the clearing pass, else set one bit
   always_comb begin
      if (cmd.clear_en) begin
         seen_wr_en   = 1'b1;
         seen_wr_addr = clear_addr_ff;
         seen_wr_data = '0;
      end else begin
         seen_wr_en   = cmd.fire && push_ok;
         seen_wr_addr = value_ff[VALUE_W-1:SEEN_COL_W];
         seen_wr_data = seen_row | (SEEN_WIDTH'(1) << value_ff[SEEN_COL_W-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_type_ff <= req_code_type'(req_type);
         value_ff    <= req_value;
      end
      if (cmd.fire) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
         member_ff <= member_in;
         empty_ff  <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff          <= CAP_RESET;
         stored_count_ff <= '0;
         read_index_ff   <= '0;
         clear_addr_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (cmd.clear_en) begin
            clear_addr_ff <= clear_addr_ff + SEEN_ROW_W'(1);
         end
         if (cmd.fire) begin
            stored_count_ff <= stored_count_in;
            read_index_ff   <= read_index_in;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.clear_last   = cmd.clear_en && (clear_addr_ff == '1);
   assign sts.out_busy     = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_popped_value = popped_ff;
   assign rsp_is_member    = member_ff;
   assign rsp_is_empty     = empty_ff;

   // the read pointer never passes the fill count
   a_index_le_count: assert property (@(posedge clock) disable iff (reset)
      read_index_ff <= stored_count_ff)
      else $error("read pointer beyond stored count");

   // fill count stays within the store
   a_count_le_depth: assert property (@(posedge clock) disable iff (reset)
      CW'(DEPTH) >= stored_count_ff)
      else $error("stored count beyond depth");

   // a commit always presents a result word next cycle
   a_fire_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.fire |=> rsp_valid_ff)
      else $error("committed result not presented");

endmodule
`default_nettype wire
